/* hdl/tftp_cts_pkg.sv */
// ----------------------------------------------------------------------------
// tftp_cts_pkg
// Types and constants for the TFTP client lock-step transfer controller.
// ----------------------------------------------------------------------------
package tftp_cts_pkg;

  // Event codes carried in tuser
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_RX      = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // TFTP opcodes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RRQ   = 3'd1;
  localparam logic [2:0] OP_WRQ   = 3'd2;
  localparam logic [2:0] OP_DATA  = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;
  localparam logic [15:0] RX_OP_DATA  = 16'd3;
  localparam logic [15:0] RX_OP_ACK   = 16'd4;
  localparam logic [15:0] RX_OP_ERROR = 16'd5;

  // Result status codes
  localparam logic [2:0] ST_CONTINUE  = 3'd0;
  localparam logic [2:0] ST_COMPLETE  = 3'd1;
  localparam logic [2:0] ST_PEER_ERR  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_RETRY_OUT = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_DIRECTION   = 2'd0;
  localparam logic [1:0] REG_MODE        = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [10:0] HEADER_BYTES = 11'd4;
  localparam logic [7:0]  TMO_MAX      = 8'hff;
  localparam logic [7:0]  RETRY_RESET  = 8'd5;

  // Port widths
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  // One result item
  typedef struct packed {
    logic [31:0] total_bytes;
    logic [31:0] blocks_done;
    logic [7:0]  peer_error_code;
    logic        block_mismatch;
    logic [9:0]  send_payload_length;
    logic [15:0] send_block;
    logic [2:0]  send_opcode;
    logic        send_valid;
  } result_t;

endpackage

/* hdl/tftp_client_transfer_step_top.sv */
// ----------------------------------------------------------------------------
// Result path: an accepted input item passes through the input register, then
//   the result register.
// Throughput: one item per cycle while the output is not stalled; each event
//   only needs compares, one increment and saturating adds on the state registers.
// Reset: asynchronous active-low; clears phase (idle), all counters, the
//   remembered packet and the pipeline valids; config returns to defaults.
// ----------------------------------------------------------------------------
// tftp_client_transfer_step_top
// Lock-step TFTP client control: takes start / packet / timeout events and
// returns status plus the packet to transmit.
// ----------------------------------------------------------------------------
module tftp_client_transfer_step_top #(
  parameter int unsigned BLOCK_PAYLOAD = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [tftp_cts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tftp_cts_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: rx_opcode, rx_block, rx_payload_length, rx_error_byte,
  //        next_chunk_length, zero fill
  input  logic [tftp_cts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: command
  input  logic [tftp_cts_pkg::CMD_W-1:0]       s_axis_tuser_i,
  // output stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: send_valid, send_opcode, send_block, send_payload_length,
  //        block_mismatch, peer_error_code, blocks_done, total_bytes, zero fill
  output logic [tftp_cts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [tftp_cts_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  import tftp_cts_pkg::*;

  localparam logic [31:0] BlockLen = 32'(BLOCK_PAYLOAD);

  // config registers (transfer mode writes are ignored, nothing is stored for it)
  logic       dir_q;
  logic [7:0] retry_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q         <= 1'b0;
      retry_limit_q <= RETRY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION:   dir_q         <= cfg_wdata_i[0];
        REG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_vld_q, out_vld_q;
  logic out_adv, fire;

  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && out_adv;
  assign s_axis_tready_o = !in_vld_q || out_adv;

  // input register
  logic [CMD_W-1:0]      in_cmd_q;
  logic [IN_TDATA_W-1:0] in_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i;
    end
  end

  logic [15:0] rx_opcode, rx_block;
  logic [9:0]  rx_len, chunk;
  logic [7:0]  rx_err;

  assign rx_opcode = in_data_q[15:0];
  assign rx_block  = in_data_q[31:16];
  assign rx_len    = in_data_q[41:32];
  assign rx_err    = in_data_q[49:42];
  assign chunk     = in_data_q[59:50];

  // transfer state
  phase_e      phase_q, phase_d;
  logic [15:0] acked_q, acked_d;
  logic [7:0]  tmo_q, tmo_d;
  logic [2:0]  last_op_q, last_op_d;
  logic [15:0] last_blk_q, last_blk_d;
  logic [9:0]  last_len_q, last_len_d;
  logic [31:0] blk_cnt_q, blk_cnt_d;
  logic [31:0] byte_cnt_q, byte_cnt_d;

  // per-event helpers
  logic [15:0] acked_inc;
  logic [7:0]  tmo_inc;
  logic [9:0]  chunk_cl;
  logic [32:0] blk_sum, rd_sum, wr_sum;
  logic [31:0] blk_sat, rd_sat, wr_sat;
  logic        running;
  logic [2:0]  status;
  logic        send, mismatch;
  logic [7:0]  perr;
  result_t     res_d, res_q;
  logic [2:0]  status_q;

  assign acked_inc = acked_q + 16'd1;
  assign tmo_inc   = (tmo_q == TMO_MAX) ? TMO_MAX : tmo_q + 8'd1;
  assign chunk_cl  = ({22'd0, chunk} > BlockLen) ? BlockLen[9:0] : chunk;
  assign running   = (phase_q == PH_RUN);

  // saturating counter adds
  assign blk_sum = {1'b0, blk_cnt_q} + 33'd1;
  assign rd_sum  = {1'b0, byte_cnt_q} + {23'd0, rx_len};
  assign wr_sum  = {1'b0, byte_cnt_q} + {22'd0, {1'b0, chunk_cl} + HEADER_BYTES};
  assign blk_sat = blk_sum[32] ? '1 : blk_sum[31:0];
  assign rd_sat  = rd_sum[32] ? '1 : rd_sum[31:0];
  assign wr_sat  = wr_sum[32] ? '1 : wr_sum[31:0];

  // event decode and next state
  always_comb begin
    phase_d    = phase_q;
    acked_d    = acked_q;
    tmo_d      = tmo_q;
    last_op_d  = last_op_q;
    last_blk_d = last_blk_q;
    last_len_d = last_len_q;
    blk_cnt_d  = blk_cnt_q;
    byte_cnt_d = byte_cnt_q;
    status     = ST_IGNORED;
    send       = 1'b0;
    mismatch   = 1'b0;
    perr       = 8'd0;

    case (in_cmd_q)
      CMD_START: begin
        acked_d    = 16'd0;
        tmo_d      = 8'd0;
        blk_cnt_d  = 32'd0;
        byte_cnt_d = 32'd0;
        last_op_d  = dir_q ? OP_WRQ : OP_RRQ;
        last_blk_d = 16'd0;
        last_len_d = 10'd0;
        phase_d    = PH_RUN;
        status     = ST_CONTINUE;
        send       = 1'b1;
      end
      CMD_RX: begin
        if (running) begin
          tmo_d = 8'd0;
          if (rx_opcode == RX_OP_ERROR) begin
            status  = ST_PEER_ERR;
            perr    = rx_err;
            phase_d = PH_DONE;
          end else if (!dir_q && rx_opcode == RX_OP_DATA) begin
            // read: expect next block, answer with ACK
            if (rx_block == acked_inc) begin
              acked_d    = rx_block;
              blk_cnt_d  = blk_sat;
              byte_cnt_d = rd_sat;
              last_op_d  = OP_ACK;
              last_blk_d = rx_block;
              last_len_d = 10'd0;
              send       = 1'b1;
              if ({22'd0, rx_len} < BlockLen) begin
                status  = ST_COMPLETE;
                phase_d = PH_DONE;
              end else begin
                status = ST_CONTINUE;
              end
            end else begin
              status   = ST_CONTINUE;
              send     = 1'b1;
              mismatch = 1'b1;
            end
          end else if (dir_q && rx_opcode == RX_OP_ACK) begin
            // write: expect ACK of current block, send next DATA
            if (rx_block == acked_q) begin
              acked_d   = acked_inc;
              blk_cnt_d = blk_sat;
              if (chunk_cl == 10'd0) begin
                status  = ST_COMPLETE;
                phase_d = PH_DONE;
              end else begin
                byte_cnt_d = wr_sat;
                last_op_d  = OP_DATA;
                last_blk_d = acked_inc;
                last_len_d = chunk_cl;
                status     = ST_CONTINUE;
                send       = 1'b1;
              end
            end else begin
              status   = ST_CONTINUE;
              send     = 1'b1;
              mismatch = 1'b1;
            end
          end else begin
            status  = ST_UNKNOWN;
            phase_d = PH_DONE;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (running) begin
          tmo_d = tmo_inc;
          if (tmo_inc >= retry_limit_q) begin
            status  = ST_RETRY_OUT;
            phase_d = PH_DONE;
          end else begin
            status = ST_CONTINUE;
            send   = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // result fields from the packet remembered after this event
    res_d                     = '0;
    res_d.send_valid          = send;
    res_d.block_mismatch      = mismatch;
    res_d.peer_error_code     = perr;
    res_d.blocks_done         = blk_cnt_d;
    res_d.total_bytes         = byte_cnt_d;
    if (send) begin
      res_d.send_opcode = last_op_d;
      if (last_op_d == OP_DATA || last_op_d == OP_ACK) begin
        res_d.send_block = last_blk_d;
      end
      if (last_op_d == OP_DATA) begin
        res_d.send_payload_length = last_len_d;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      acked_q    <= 16'd0;
      tmo_q      <= 8'd0;
      last_op_q  <= OP_NONE;
      last_blk_q <= 16'd0;
      last_len_q <= 10'd0;
      blk_cnt_q  <= 32'd0;
      byte_cnt_q <= 32'd0;
    end else if (fire) begin
      phase_q    <= phase_d;
      acked_q    <= acked_d;
      tmo_q      <= tmo_d;
      last_op_q  <= last_op_d;
      last_blk_q <= last_blk_d;
      last_len_q <= last_len_d;
      blk_cnt_q  <= blk_cnt_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q    <= res_d;
      status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {1'b0, res_q};

  // assertions
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q && !m_axis_tready_i))
    else $error("input stalled while pipeline has room");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_cmd_q == CMD_START) |=> (phase_q == PH_RUN))
    else $error("start event did not enter running phase");

  a_mismatch_resends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.block_mismatch) |->
      (res_q.send_valid && status_q == ST_CONTINUE))
    else $error("block mismatch without resend");

  a_no_send_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res_q.send_valid) |->
      (res_q.send_opcode == OP_NONE && res_q.send_block == 16'd0 &&
       res_q.send_payload_length == 10'd0))
    else $error("send fields set without a send");

  a_perr_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_q.peer_error_code != 8'd0) |-> (status_q == ST_PEER_ERR))
    else $error("peer error code outside peer error status");

endmodule
